FILE: src/rhnt_pkg.sv
// Shared types, codes and name helpers for the Robin Hood name table.
`default_nettype none

package rhnt_pkg;

   // Longest name is NAME_BYTES-1 bytes
   localparam int NAME_BYTES = 16;

   // Command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_REJECT    = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // One input transfer
   typedef struct packed {
      logic        command;
      logic [63:0] name_low;
      logic [55:0] name_high;
      logic [3:0]  name_length;
      logic [15:0] location;
   } req_type;

   // One result transfer
   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  slot_index;
      logic [15:0] found_location;
   } rsp_type;

   // Slot contents, probe length kept beside it in the store
   typedef struct packed {
      logic [63:0] name_low;
      logic [55:0] name_high;
      logic [3:0]  length;
      logic [15:0] hash;
      logic [15:0] location;
   } entry_type;

   // Zero name bytes 0..7 at or above the length
   function automatic logic [63:0] keep_low_bytes(logic [63:0] v, logic [3:0] len);
      logic [63:0] r;
      r = v;
      for (int k = 0; k < 8; k++) begin
         if (k >= int'(len)) begin
            r[8*k +: 8] = 8'h00;
         end
      end
      return r;
   endfunction

   // Zero name bytes 8..14 at or above the length
   function automatic logic [55:0] keep_high_bytes(logic [55:0] v, logic [3:0] len);
      logic [55:0] r;
      r = v;
      for (int k = 0; k < 7; k++) begin
         if ((k + 8) >= int'(len)) begin
            r[8*k +: 8] = 8'h00;
         end
      end
      return r;
   endfunction

   // Valid name length: 1 to NAME_BYTES-1
   function automatic logic length_ok(logic [3:0] len);
      return (len != 4'd0) && (int'(len) <= NAME_BYTES - 1);
   endfunction

endpackage

`default_nettype wire

FILE: src/robin_hood_name_table.sv
// Robin Hood name table: probing sequencer around the slot memory and hash unit.
//
//  channel | ports                           | transfer
//  --------+---------------------------------+---------------------------------
//  input   | start, busy, req_item           | edge with start high, busy low
//  result  | rsp_strobe, rsp_item            | edge ending the strobe cycle
//
// After reset a clearing pass writes every slot, with busy high.
// Bad length, or insert into a full table: result strobes the cycle after the
// transfer and busy stays low.
// Otherwise: hash and home slot from the reciprocal multiply pipeline, then
// one slot probed per cycle through the single-port read of the slot memory, and
// the result strobes in the cycle after the last probe.
// The receiver cannot stall; each result is marked by rsp_strobe for exactly one cycle.
`default_nettype none

module robin_hood_name_table #(
   parameter int TABLE_SLOTS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire rhnt_pkg::req_type req_item,
   output logic                   rsp_strobe,
   output rhnt_pkg::rsp_type      rsp_item
);
   import rhnt_pkg::*;

   localparam int IW = $clog2(TABLE_SLOTS);
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam logic [IW-1:0] LAST_SLOT  = IW'(TABLE_SLOTS - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_SLOTS);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_HASH  = 2'd2;
   localparam logic [1:0] S_PROBE = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] count_ff, count_in;
   logic          go_ff, go_in;
   logic          strobe_ff, strobe_in;
   logic          cmd_ff, cmd_in;
   entry_type     carry_ff, carry_in;
   rsp_type       rsp_ff, rsp_in;

   logic          hash_valid;
   logic [15:0]   hash_value;
   logic [IW-1:0] hash_home;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_entry;
   logic [IW-1:0] wr_psl;
   logic [IW-1:0] rd_addr;
   entry_type     rd_entry;
   logic [IW-1:0] rd_psl;

   logic [IW-1:0] idx_next;
   logic          occupied;
   logic          key_match;
   logic [IW+5:0] slot_wide;

   rhnt_hash #(
      .SLOTS   (TABLE_SLOTS),
      .INDEX_W (IW)
   ) u_hash (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (go_ff),
      .in_length (carry_ff.length),
      .in_bytes  (carry_ff.name_low[23:0]),
      .out_valid (hash_valid),
      .out_hash  (hash_value),
      .out_home  (hash_home)
   );

   rhnt_store #(
      .DEPTH  (TABLE_SLOTS),
      .ADDR_W (IW),
      .PSL_W  (IW)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .wr_psl   (wr_psl),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .rd_psl   (rd_psl)
   );

   // Probe helpers on the slot just read
   assign idx_next  = (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;
   assign occupied  = (rd_entry.length != 4'd0);
   assign key_match = (rd_entry.length == carry_ff.length) &&
                      (rd_entry.hash == carry_ff.hash) &&
                      (rd_entry.name_low == carry_ff.name_low) &&
                      (rd_entry.name_high == carry_ff.name_high);
   assign slot_wide = {6'd0, idx_ff};

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      count_in  = count_ff;
      go_in     = 1'b0;
      strobe_in = 1'b0;
      cmd_in    = cmd_ff;
      carry_in  = carry_ff;
      rsp_in    = rsp_ff;
      rd_addr   = idx_next;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_entry  = carry_ff;
      wr_psl    = cnt_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en    = 1'b1;
            wr_entry = '0;
            wr_psl   = '0;
            idx_in   = idx_next;
            if (idx_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               cmd_in             = req_item.command;
               carry_in.name_low  = keep_low_bytes(req_item.name_low, req_item.name_length);
               carry_in.name_high = keep_high_bytes(req_item.name_high, req_item.name_length);
               carry_in.length    = req_item.name_length;
               carry_in.hash      = '0;
               carry_in.location  = req_item.location;
               if (!length_ok(req_item.name_length) ||
                   (req_item.command == CMD_INSERT && count_ff == FULL_COUNT)) begin
                  // answered at once
                  strobe_in = 1'b1;
                  rsp_in    = '0;
                  rsp_in.status = (req_item.command == CMD_INSERT) ? ST_REJECT
                                                                   : ST_NOT_FOUND;
               end else begin
                  go_in    = 1'b1;
                  state_in = S_HASH;
               end
            end
         end

         S_HASH: begin
            rd_addr = hash_home;
            if (hash_valid) begin
               idx_in        = hash_home;
               carry_in.hash = hash_value;
               cnt_in        = '0;
               state_in      = S_PROBE;
            end
         end

         S_PROBE: begin
            if (cmd_ff == CMD_INSERT) begin
               if (!occupied) begin
                  // empty slot: drop the carried entry here
                  wr_en     = 1'b1;
                  count_in  = count_ff + 1'b1;
                  rsp_in    = '0;
                  rsp_in.status = ST_DONE;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  if (cnt_ff > rd_psl) begin
                     // swap with the richer resident
                     wr_en    = 1'b1;
                     carry_in = rd_entry;
                     cnt_in   = rd_psl + 1'b1;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
                  idx_in = idx_next;
               end
            end else begin
               if (!occupied || cnt_ff > rd_psl) begin
                  rsp_in    = '0;
                  rsp_in.status = ST_NOT_FOUND;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end else if (key_match) begin
                  rsp_in.status         = ST_DONE;
                  rsp_in.slot_index     = slot_wide[5:0];
                  rsp_in.found_location = rd_entry.location;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end else if (cnt_ff == LAST_SLOT) begin
                  // whole table probed
                  rsp_in    = '0;
                  rsp_in.status = ST_NOT_FOUND;
                  strobe_in = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  idx_in = idx_next;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         idx_ff    <= '0;
         cnt_ff    <= '0;
         count_ff  <= '0;
         go_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         cnt_ff    <= cnt_in;
         count_ff  <= count_in;
         go_ff     <= go_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      carry_ff <= carry_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   // Entry count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above table size");

   // A successful insert adds exactly one entry
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(reset) && cmd_ff == CMD_INSERT && rsp_item.status == ST_DONE)
      |-> count_ff == $past(count_ff) + 1'b1)
      else $error("insert done without count step");

   // The count moves only with a result
   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      (!rsp_strobe && !$past(reset)) |-> count_ff == $past(count_ff))
      else $error("entry count changed without a result");

   // No result while the clearing pass runs
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_strobe)
      else $error("result during clearing pass");

endmodule

`default_nettype wire

FILE: src/rhnt_hash.sv
// Name hash and home slot pipeline (three stages).
`default_nettype none

module rhnt_hash #(
   parameter int SLOTS   = 64,
   parameter int INDEX_W = 6
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [3:0]         in_length,
   input  wire logic [23:0]        in_bytes,
   output logic                    out_valid,
   output logic [15:0]             out_hash,
   output logic [INDEX_W-1:0]      out_home
);
   import rhnt_pkg::*;

   // floor(2^32 / SLOTS): quotient estimate is exact or one low
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOTS);

   logic [2:0]  valid_ff;
   logic [15:0] hash1_ff, hash2_ff, hash3_ff;
   logic [15:0] quot_ff;
   logic [INDEX_W-1:0] home_ff;

   logic [11:0] len_prod;
   logic [15:0] hash1_in;
   logic [47:0] recip_prod;
   logic [31:0] rem_raw;
   logic [31:0] rem_fix;

   // Stage 1: length times byte 0, mixed with bytes 1 and 2 for names of 3 bytes or more
   always_comb begin
      len_prod = 12'(in_length) * 12'(in_bytes[7:0]);
      hash1_in = {4'd0, len_prod};
      if (in_length >= 4'd3) begin
         hash1_in = hash1_in ^ {in_bytes[23:16], in_bytes[15:8]};
      end
   end

   // Stage 2: quotient estimate by reciprocal
   assign recip_prod = 48'(hash1_ff) * 48'(RECIP);

   // Stage 3: remainder with one correction step
   always_comb begin
      rem_raw = 32'(hash2_ff) - (32'(quot_ff) * 32'(SLOTS));
      rem_fix = rem_raw;
      if (rem_raw >= 32'(SLOTS)) begin
         rem_fix = rem_raw - 32'(SLOTS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      hash1_ff <= hash1_in;
      hash2_ff <= hash1_ff;
      quot_ff  <= recip_prod[47:32];
      hash3_ff <= hash2_ff;
      home_ff  <= rem_fix[INDEX_W-1:0];
   end

   assign out_valid = valid_ff[2];
   assign out_hash  = hash3_ff;
   assign out_home  = home_ff;

endmodule

`default_nettype wire

FILE: src/rhnt_store.sv
// Slot memory: one write port, one registered read port.
`default_nettype none

module rhnt_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int PSL_W  = 6
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire rhnt_pkg::entry_type   wr_entry,
   input  wire logic [PSL_W-1:0]      wr_psl,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output rhnt_pkg::entry_type        rd_entry,
   output logic [PSL_W-1:0]           rd_psl
);
   import rhnt_pkg::*;

   localparam int WORD_W = $bits(entry_type) + PSL_W;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_psl, wr_entry};
      end
      rd_word_ff <= mem[rd_addr];
   end

   assign rd_entry = entry_type'(rd_word_ff[$bits(entry_type)-1:0]);
   assign rd_psl   = rd_word_ff[WORD_W-1 -: PSL_W];

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for robin_hood_name_table: directed and random name inserts and lookups.
`default_nettype none

module tb;
   import rhnt_pkg::*;

   localparam int TABLE_SLOTS = 64;
   localparam int RANDOM_ITEMS = 950;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT = 500000;

   // One stored entry of the shadow table
   typedef struct {
      logic [63:0] low;
      logic [55:0] high;
      logic [3:0]  len;
      logic [15:0] hash;
      logic [15:0] loc;
      int          probe_len;
   } shadow_slot_t;

   // One row of the directed stimulus
   typedef struct {
      req_type    item;
      bit         typed;
      logic [1:0] want_status;
   } stim_row_t;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   shadow_slot_t shadow_slots[TABLE_SLOTS];
   int           table_entries;
   rsp_type      expected_results[$];
   req_type      stored_names[$];
   int           error_total = 0;
   int           cycle_count = 0;
   int           burst_left = 0;

   robin_hood_name_table #(.TABLE_SLOTS(TABLE_SLOTS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bytes 0..7 that lie inside the name length
   function automatic logic [63:0] low_byte_mask(logic [3:0] len);
      if (len >= 4'd8) return '1;
      return (64'd1 << (8 * int'(len))) - 64'd1;
   endfunction

   // Bytes 8..14 that lie inside the name length
   function automatic logic [55:0] high_byte_mask(logic [3:0] len);
      if (len <= 4'd8) return '0;
      if (len == 4'd15) return '1;
      return (56'd1 << (8 * (int'(len) - 8))) - 56'd1;
   endfunction

   // Length times byte 0, folded with bytes 1 and 2 for names of 3 bytes or more
   function automatic logic [15:0] name_hash16(logic [63:0] low, logic [3:0] len);
      logic [15:0] h;
      h = 16'(int'(len) * int'(low[7:0]));
      if (len >= 4'd3) h = h ^ {low[23:16], low[15:8]};
      return h;
   endfunction

   function automatic void clear_shadow_table();
      for (int k = 0; k < TABLE_SLOTS; k++) begin
         shadow_slots[k] = '{low: '0, high: '0, len: '0, hash: '0, loc: '0, probe_len: 0};
      end
      table_entries = 0;
   endfunction

   // Applies one command to the shadow table and returns the result it gives
   function automatic rsp_type predict_table_op(req_type r);
      rsp_type      res;
      shadow_slot_t carried;
      shadow_slot_t tmp;
      logic [63:0]  low;
      logic [55:0]  high;
      logic [15:0]  h;
      int           idx;
      bit           len_valid;

      res = '0;
      low = r.name_low & low_byte_mask(r.name_length);
      high = r.name_high & high_byte_mask(r.name_length);
      h = name_hash16(low, r.name_length);
      idx = int'(h) % TABLE_SLOTS;
      len_valid = (r.name_length != 4'd0) && (int'(r.name_length) <= NAME_BYTES - 1);

      if (r.command == CMD_INSERT) begin
         if (!len_valid || table_entries >= TABLE_SLOTS) begin
            res.status = ST_REJECT;
            return res;
         end
         carried = '{low: low, high: high, len: r.name_length, hash: h,
                     loc: r.location, probe_len: 0};
         // Walk the cluster, handing the slot to whichever entry is further from home
         for (int steps = 0; steps < TABLE_SLOTS && shadow_slots[idx].len != 4'd0; steps++) begin
            if (carried.probe_len > shadow_slots[idx].probe_len) begin
               tmp = shadow_slots[idx];
               shadow_slots[idx] = carried;
               carried = tmp;
            end
            idx = (idx + 1) % TABLE_SLOTS;
            carried.probe_len++;
         end
         shadow_slots[idx] = carried;
         table_entries++;
         res.status = ST_DONE;
         return res;
      end

      res.status = ST_NOT_FOUND;
      if (!len_valid) return res;
      // Stop at an empty slot or once we are further out than the resident
      for (int steps = 0; steps < TABLE_SLOTS; steps++) begin
         if (shadow_slots[idx].len == 4'd0 || steps > shadow_slots[idx].probe_len) return res;
         if (shadow_slots[idx].len == r.name_length && shadow_slots[idx].hash == h &&
             shadow_slots[idx].low == low && shadow_slots[idx].high == high) begin
            res.status = ST_DONE;
            res.slot_index = 6'(idx);
            res.found_location = shadow_slots[idx].loc;
            return res;
         end
         idx = (idx + 1) % TABLE_SLOTS;
      end
      return res;
   endfunction

   function automatic stim_row_t dir_row(logic cmd, logic [63:0] low, logic [55:0] high,
                                         logic [3:0] len, logic [15:0] loc,
                                         bit typed, logic [1:0] st);
      stim_row_t row;
      row.item = '{command: cmd, name_low: low, name_high: high,
                   name_length: len, location: loc};
      row.typed = typed;
      row.want_status = st;
      return row;
   endfunction

   // Random command: inserts fill the table, lookups mostly hit stored names
   function automatic req_type random_request();
      req_type     r;
      req_type     base;
      logic [63:0] lm;
      logic [55:0] hm;
      int          kind;
      int          bit_pos;

      r.name_low = {$urandom, $urandom};
      r.name_high = 56'({$urandom, $urandom});
      r.name_length = 4'($urandom_range(1, 15));
      r.location = 16'($urandom);
      // Small leading bytes crowd names into a few home slots
      if ($urandom_range(0, 1) == 0) begin
         r.name_low[7:0] = 8'($urandom_range(0, 3));
         r.name_low[23:8] = 16'($urandom_range(0, 1));
      end
      kind = $urandom_range(0, 99);
      if (kind < ((table_entries < TABLE_SLOTS) ? 18 : 8)) begin
         r.command = CMD_INSERT;
         if ($urandom_range(0, 29) == 0) r.name_length = 4'd0;
         return r;
      end
      r.command = CMD_LOOKUP;
      if (kind < 75 && stored_names.size() != 0) begin
         // Known name, fresh bytes beyond its length
         base = stored_names[$urandom_range(0, stored_names.size() - 1)];
         lm = low_byte_mask(base.name_length);
         hm = high_byte_mask(base.name_length);
         r.name_length = base.name_length;
         r.name_low = (base.name_low & lm) | (r.name_low & ~lm);
         r.name_high = (base.name_high & hm) | (r.name_high & ~hm);
         // Near miss: one bit inside the name flipped
         if (kind >= 65) begin
            bit_pos = $urandom_range(0, 8 * int'(r.name_length) - 1);
            if (bit_pos < 64) r.name_low[bit_pos] = ~r.name_low[bit_pos];
            else r.name_high[bit_pos - 64] = ~r.name_high[bit_pos - 64];
         end
      end else if (kind > 97) begin
         r.name_length = 4'd0;
      end
      return r;
   endfunction

   // Drives one command at the falling edge and waits for its transfer
   task automatic send_item(input req_type r, input bit typed, input logic [1:0] st);
      rsp_type predicted;
      int      gap;

      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      predicted = predict_table_op(r);
      if (typed) begin
         predicted = '0;
         predicted.status = st;
      end
      expected_results.push_back(predicted);
      if (r.command == CMD_INSERT && predicted.status == ST_DONE) stored_names.push_back(r);
      @(negedge clock);
   endtask

   // Stimulus
   initial begin
      stim_row_t directed_rows[$];

      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      clear_shadow_table();

      directed_rows = '{
         dir_row(CMD_LOOKUP, 64'h41, 56'h0, 4'd1, 16'h0, 1, ST_NOT_FOUND),
         dir_row(CMD_INSERT, '1, '1, 4'd0, 16'hFFFF, 1, ST_REJECT),
         dir_row(CMD_LOOKUP, '1, '1, 4'd0, 16'h0, 1, ST_NOT_FOUND),
         dir_row(CMD_INSERT, '1, '1, 4'd1, 16'hFFFF, 1, ST_DONE),
         dir_row(CMD_LOOKUP, 64'hFF, 56'h0, 4'd1, 16'h0, 0, ST_DONE),
         dir_row(CMD_INSERT, '1, '1, 4'd15, 16'h0000, 1, ST_DONE),
         dir_row(CMD_LOOKUP, '1, '1, 4'd15, 16'h0, 0, ST_DONE),
         dir_row(CMD_INSERT, 64'hFF, 56'h0, 4'd1, 16'h1234, 1, ST_DONE),
         dir_row(CMD_LOOKUP, 64'hFF, 56'h0, 4'd1, 16'h0, 0, ST_DONE),
         dir_row(CMD_INSERT, 64'h0, 56'h0, 4'd3, 16'h0001, 1, ST_DONE),
         dir_row(CMD_INSERT, 64'h0, 56'h0, 4'd3, 16'h0002, 1, ST_DONE),
         dir_row(CMD_INSERT, 64'h0100_0000, 56'h0, 4'd4, 16'h0003, 1, ST_DONE),
         dir_row(CMD_INSERT, 64'hFFFF_FFFF_FF00_0000, 56'h0, 4'd2, 16'h0004, 1, ST_DONE),
         dir_row(CMD_LOOKUP, 64'h0, 56'h0, 4'd3, 16'h0, 0, ST_DONE),
         dir_row(CMD_LOOKUP, 64'h0100_0000, 56'h0, 4'd4, 16'h0, 0, ST_DONE),
         dir_row(CMD_LOOKUP, 64'hAB00_0000, 56'h0, 4'd2, 16'h0, 0, ST_DONE),
         dir_row(CMD_LOOKUP, 64'h0200_0000, 56'h0, 4'd4, 16'h0, 0, ST_DONE),
         dir_row(CMD_INSERT, 64'h0807_0605_0403_0201, 56'hAAAAAA, 4'd8, 16'h8000, 1, ST_DONE),
         dir_row(CMD_LOOKUP, 64'h0807_0605_0403_0201, 56'h555555, 4'd8, 16'h0, 0, ST_DONE),
         dir_row(CMD_LOOKUP, 64'h0807_0605_0403_0201, 56'h0, 4'd9, 16'h0, 0, ST_DONE),
         dir_row(CMD_INSERT, 64'h0807_0605_0403_0201, 56'hFF_FFFF_FFFF_FF09, 4'd9,
                 16'h0909, 1, ST_DONE),
         dir_row(CMD_LOOKUP, 64'h0807_0605_0403_0201, 56'h09, 4'd9, 16'h0, 0, ST_DONE),
         dir_row(CMD_INSERT, 64'h01, 56'h0, 4'd1, 16'h0005, 1, ST_DONE),
         dir_row(CMD_LOOKUP, 64'h01, 56'h0, 4'd1, 16'h0, 0, ST_DONE),
         dir_row(CMD_LOOKUP, 64'h0, 56'h0, 4'd3, 16'h0, 0, ST_DONE)
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[k]) begin
         send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want_status);
      end
      repeat (RANDOM_ITEMS) send_item(random_request(), 0, ST_DONE);
      start <= 1'b0;

      // Drain outstanding results, then give the block time to misbehave
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_total == 0) begin
         $display("robin_hood_name_table test passed");
      end else begin
         $display("robin_hood_name_table test failed");
      end
      $finish;
   end

   // Result checker: each strobe is compared with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with none expected: status %0d", rsp_item.status);
            error_total++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_item.status);
               error_total++;
            end
            if (rsp_item.slot_index !== want.slot_index) begin
               $error("slot_index expected %0d actual %0d", want.slot_index,
                      rsp_item.slot_index);
               error_total++;
            end
            if (rsp_item.found_location !== want.found_location) begin
               $error("found_location expected %h actual %h", want.found_location,
                      rsp_item.found_location);
               error_total++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("robin_hood_name_table test failed");
         $finish;
      end
   end

endmodule

`default_nettype wire

FILE: robin_hood_name_table.f
src/rhnt_pkg.sv
src/rhnt_hash.sv
src/rhnt_store.sv
src/robin_hood_name_table.sv
tb/tb.sv
